FILE: design/mmfs_pkg.sv
package mmfs_pkg;

	localparam int unsigned MAX_FEATURES_DEF = 64;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned INDEX_W   = 6;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned SCALED_W  = 49;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DIFF_W    = VALUE_W + 1;
	localparam int unsigned QUO_W     = VALUE_W + FRAC_BITS;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

	localparam logic MODE_TRAIN = 1'b0;
	localparam logic MODE_SCALE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_CONSTANT  = 2'd1,
		ST_UNTRAINED = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic write_back;
		logic div_load;
		logic div_step;
		logic out_direct;
		logic out_div;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_train;
		logic needs_div;
	} dp_stat_t;

endpackage

FILE: design/mmfs_ctrl.sv
module mmfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mmfs_pkg::dp_stat_t  stat,
	output mmfs_pkg::ctl_cmd_t  cmd,
	output logic                busy
);

	localparam int unsigned STEPS = mmfs_pkg::QUO_W;
	localparam int unsigned CW    = $clog2(STEPS);
	localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] step_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.capture = start;
			S_EVAL: begin
				if (stat.is_train) begin
					cmd.write_back = 1'b1;
				end else if (stat.needs_div) begin
					cmd.div_load = 1'b1;
				end else begin
					cmd.out_direct = 1'b1;
				end
			end
			S_DIV: cmd.div_step = 1'b1;
			S_FIN: cmd.out_div = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!stat.is_train && stat.needs_div) begin
						state_q <= S_DIV;
						step_q  <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/mmfs_datapath.sv
module mmfs_datapath #(
	parameter int unsigned MAX_FEATURES = mmfs_pkg::MAX_FEATURES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mmfs_pkg::ctl_cmd_t                      cmd,
	output mmfs_pkg::dp_stat_t                      stat,
	input  logic                                    cfg_we,
	input  logic [mmfs_pkg::COUNT_W-1:0]            cfg_data,
	input  logic                                    mode,
	input  logic [mmfs_pkg::INDEX_W-1:0]            feature_index,
	input  logic signed [mmfs_pkg::VALUE_W-1:0]     value,
	output logic                                    done,
	output logic signed [mmfs_pkg::SCALED_W-1:0]    scaled_value,
	output logic [mmfs_pkg::INDEX_W-1:0]            out_feature_index,
	output logic [mmfs_pkg::STATUS_W-1:0]           status
);

	localparam int unsigned VW = mmfs_pkg::VALUE_W;
	localparam int unsigned DW = mmfs_pkg::DIFF_W;
	localparam int unsigned QW = mmfs_pkg::QUO_W;
	localparam int unsigned FB = mmfs_pkg::FRAC_BITS;
	localparam int unsigned SW = mmfs_pkg::SCALED_W;
	localparam int unsigned AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

	// {max, min} per feature
	logic [2*VW-1:0]                 mem_q [MAX_FEATURES];
	logic [2*VW-1:0]                 rd_q;
	logic [MAX_FEATURES-1:0]         trained_q;
	logic                            rd_trained_q;

	logic [mmfs_pkg::COUNT_W-1:0]    count_q;
	logic                            mode_q;
	logic [mmfs_pkg::INDEX_W-1:0]    idx_q;
	logic signed [VW-1:0]            value_q;
	logic                            idx_ok_q;

	logic [AW-1:0]                   rd_addr;
	logic [AW-1:0]                   wr_addr;
	logic                            idx_ok;
	logic signed [VW-1:0]            cur_min;
	logic signed [VW-1:0]            cur_max;
	logic signed [VW-1:0]            new_min;
	logic signed [VW-1:0]            new_max;
	logic signed [DW-1:0]            diff;
	logic signed [DW-1:0]            span;
	logic [DW-1:0]                   diff_mag;
	mmfs_pkg::status_t               eval_status;
	logic signed [SW-1:0]            direct_val;

	// divider
	logic [QW-1:0]                   quo_q;
	logic [VW-1:0]                   rem_q;
	logic [VW-1:0]                   dvs_q;
	logic                            neg_q;
	logic [VW:0]                     shifted;
	logic [VW:0]                     trial;

	logic                            done_q;
	logic signed [SW-1:0]            scaled_q;
	logic [mmfs_pkg::INDEX_W-1:0]    oidx_q;
	mmfs_pkg::status_t               status_q;

	assign rd_addr = AW'(feature_index);
	assign wr_addr = AW'(idx_q);
	assign idx_ok  = (mmfs_pkg::COUNT_W'(feature_index) < count_q) &&
			(32'(feature_index) < 32'(MAX_FEATURES));

	assign cur_min = rd_q[VW-1:0];
	assign cur_max = rd_q[2*VW-1:VW];

	// an untrained entry's stored min/max is ignored, so the first sample sets both
	assign new_min = (!rd_trained_q || value_q < cur_min) ? value_q : cur_min;
	assign new_max = (!rd_trained_q || value_q > cur_max) ? value_q : cur_max;

	assign diff     = DW'(value_q) - DW'(cur_min);
	assign span     = DW'(cur_max) - DW'(cur_min);
	assign diff_mag = diff[DW-1] ? DW'(-diff) : diff;

	always_comb begin
		if (!idx_ok_q) begin
			eval_status = mmfs_pkg::ST_RANGE;
		end else if (!rd_trained_q) begin
			eval_status = mmfs_pkg::ST_UNTRAINED;
		end else if (span[DW-1] || span == '0) begin
			eval_status = mmfs_pkg::ST_CONSTANT;
		end else begin
			eval_status = mmfs_pkg::ST_OK;
		end
	end

	assign direct_val = (eval_status == mmfs_pkg::ST_CONSTANT) ?
			{diff, {FB{1'b0}}} : '0;

	assign stat.is_train  = (mode_q == mmfs_pkg::MODE_TRAIN);
	assign stat.needs_div = (eval_status == mmfs_pkg::ST_OK);

	// restoring division, one quotient bit per cycle; quo_q shifts dividend out
	assign shifted = {rem_q, quo_q[QW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.write_back && idx_ok_q) begin
			mem_q[wr_addr] <= {new_max, new_min};
		end
		if (cmd.capture) begin
			rd_q         <= mem_q[rd_addr];
			rd_trained_q <= trained_q[rd_addr];
			mode_q       <= mode;
			idx_q        <= feature_index;
			value_q      <= value;
			idx_ok_q     <= idx_ok;
		end
		if (cmd.div_load) begin
			quo_q <= {diff_mag[VW-1:0], {FB{1'b0}}};
			rem_q <= '0;
			dvs_q <= span[VW-1:0];
			neg_q <= diff[DW-1];
		end else if (cmd.div_step) begin
			if (!trial[VW]) begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.out_direct) begin
			scaled_q <= direct_val;
			oidx_q   <= idx_q;
			status_q <= eval_status;
		end else if (cmd.out_div) begin
			scaled_q <= neg_q ? -SW'({1'b0, quo_q}) : SW'({1'b0, quo_q});
			oidx_q   <= idx_q;
			status_q <= mmfs_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trained_q <= '0;
			count_q   <= mmfs_pkg::COUNT_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.out_direct | cmd.out_div;
			if (cfg_we) count_q <= cfg_data;
			if (cmd.write_back && idx_ok_q) trained_q[wr_addr] <= 1'b1;
		end
	end

	assign done              = done_q;
	assign scaled_value      = scaled_q;
	assign out_feature_index = oidx_q;
	assign status            = status_q;

endmodule

FILE: design/min_max_feature_scaler_core.sv
// Per-feature min-max scaler.
// Input: pulse start with mode, feature_index and value while busy is low;
// the item transfers at that clock edge. mode 0 folds value into the stored
// min/max of the feature; mode 1 returns (value-min)/(max-min) in Q32.16.
// Results appear on scaled_value, out_feature_index and status for one cycle
// with done high; the receiver must take them, there is no back-pressure.
// Train items give no result and keep busy high through the evaluate state.
// Scale items with bad index, untrained or constant feature: done rises once
// the evaluate state has loaded the output registers. Normal scale items go
// through a radix-2 restoring divider in the divide state, one quotient bit
// per cycle for 48 bits, then the finish state: done is high in the cycle in
// which busy drops, so the next start transfers at the edge ending the done cycle.
// Write feature_count through cfg_we/cfg_data only while idle; the block does not enforce it.
// Reset (arst_n low) clears all trained flags and sets feature_count to 64;
// min/max storage is not swept, untrained entries are ignored on read.
module min_max_feature_scaler_core #(
	parameter int unsigned MAX_FEATURES = mmfs_pkg::MAX_FEATURES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    mode,
	input  logic [mmfs_pkg::INDEX_W-1:0]            feature_index,
	input  logic signed [mmfs_pkg::VALUE_W-1:0]     value,
	input  logic                                    cfg_we,
	input  logic [mmfs_pkg::COUNT_W-1:0]            cfg_data,
	output logic                                    done,
	output logic signed [mmfs_pkg::SCALED_W-1:0]    scaled_value,
	output logic [mmfs_pkg::INDEX_W-1:0]            out_feature_index,
	output logic [mmfs_pkg::STATUS_W-1:0]           status
);

	mmfs_pkg::ctl_cmd_t cmd;
	mmfs_pkg::dp_stat_t stat;

	mmfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mmfs_datapath #(
		.MAX_FEATURES (MAX_FEATURES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.mode              (mode),
		.feature_index     (feature_index),
		.value             (value),
		.done              (done),
		.scaled_value      (scaled_value),
		.out_feature_index (out_feature_index),
		.status            (status)
	);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int NFEAT = mmfs_pkg::MAX_FEATURES_DEF;

	typedef struct {
		logic [mmfs_pkg::SCALED_W-1:0] scaled;
		logic [mmfs_pkg::INDEX_W-1:0]  idx;
		mmfs_pkg::status_t             st;
	} norm_t;

	// Tracks per-feature min/max and the normalized values still owed by the block.
	class norm_board;
		logic signed [mmfs_pkg::VALUE_W-1:0] feat_min [NFEAT];
		logic signed [mmfs_pkg::VALUE_W-1:0] feat_max [NFEAT];
		bit                                  feat_trained [NFEAT];
		logic [mmfs_pkg::COUNT_W-1:0]        feat_count;
		norm_t                               expected_norms [$];
		int                                  mismatches;

		function new();
			for (int i = 0; i < NFEAT; i++) begin
				feat_min[i] = 32'sh7fff_ffff;
				feat_max[i] = 32'sh8000_0000;
				feat_trained[i] = 1'b0;
			end
			feat_count = mmfs_pkg::COUNT_RESET;
			mismatches = 0;
		endfunction

		function bit index_live(logic [mmfs_pkg::INDEX_W-1:0] idx);
			return (int'(idx) < int'(feat_count)) && (int'(idx) < NFEAT);
		endfunction

		function void absorb_item(logic m, logic [mmfs_pkg::INDEX_W-1:0] idx,
				logic signed [mmfs_pkg::VALUE_W-1:0] v);
			norm_t  e;
			longint diff;
			longint span;
			longint num;
			longint quo;
			if (m == mmfs_pkg::MODE_TRAIN) begin
				if (index_live(idx)) begin
					if (v < feat_min[idx]) feat_min[idx] = v;
					if (v > feat_max[idx]) feat_max[idx] = v;
					feat_trained[idx] = 1'b1;
				end
				return;
			end
			e.idx = idx;
			e.scaled = '0;
			if (!index_live(idx)) begin
				e.st = mmfs_pkg::ST_RANGE;
			end else if (!feat_trained[idx]) begin
				e.st = mmfs_pkg::ST_UNTRAINED;
			end else begin
				diff = longint'(v) - longint'(feat_min[idx]);
				span = longint'(feat_max[idx]) - longint'(feat_min[idx]);
				num = diff * 65536;
				if (span <= 0) begin
					e.scaled = num[mmfs_pkg::SCALED_W-1:0];
					e.st = mmfs_pkg::ST_CONSTANT;
				end else begin
					// signed division truncates toward zero
					quo = num / span;
					e.scaled = quo[mmfs_pkg::SCALED_W-1:0];
					e.st = mmfs_pkg::ST_OK;
				end
			end
			expected_norms.insert(expected_norms.size(), e);
		endfunction

		function void check_norm(logic [mmfs_pkg::SCALED_W-1:0] sv,
				logic [mmfs_pkg::INDEX_W-1:0] idx,
				logic [mmfs_pkg::STATUS_W-1:0] st);
			norm_t e;
			if (expected_norms.size() == 0) begin
				$display("%0t: unexpected result scaled=%0d idx=%0d status=%0d",
					$time, $signed(sv), idx, st);
				mismatches++;
				return;
			end
			e = expected_norms.pop_front();
			if (sv !== e.scaled) begin
				$display("%0t: scaled_value expected %0d actual %0d", $time,
					$signed(e.scaled), $signed(sv));
				mismatches++;
			end
			if (idx !== e.idx) begin
				$display("%0t: out_feature_index expected %0d actual %0d", $time,
					e.idx, idx);
				mismatches++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				mismatches++;
			end
		endfunction
	endclass

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  start = 1'b0;
	logic                                  busy;
	logic                                  mode = mmfs_pkg::MODE_TRAIN;
	logic [mmfs_pkg::INDEX_W-1:0]          feature_index = '0;
	logic signed [mmfs_pkg::VALUE_W-1:0]   value = '0;
	logic                                  cfg_we = 1'b0;
	logic [mmfs_pkg::COUNT_W-1:0]          cfg_data = '0;
	logic                                  done;
	logic signed [mmfs_pkg::SCALED_W-1:0]  scaled_value;
	logic [mmfs_pkg::INDEX_W-1:0]          out_feature_index;
	logic [mmfs_pkg::STATUS_W-1:0]         status;

	norm_board sb;

	min_max_feature_scaler_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.feature_index     (feature_index),
		.value             (value),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.done              (done),
		.scaled_value      (scaled_value),
		.out_feature_index (out_feature_index),
		.status            (status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done && sb != null)
			sb.check_norm(scaled_value, out_feature_index, status);
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_item(input logic m, input logic [mmfs_pkg::INDEX_W-1:0] idx,
			input logic signed [mmfs_pkg::VALUE_W-1:0] v, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct)
			hold_off(1);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		feature_index <= idx;
		value <= v;
		// transfer happens at the first edge that sees busy low
		do
			@(posedge clk);
		while (busy);
		sb.absorb_item(m, idx, v);
	endtask

	task automatic wait_drained();
		hold_off(1);
		while (sb.expected_norms.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [mmfs_pkg::COUNT_W-1:0] cnt);
		wait_drained();
		// a train item may still be in flight
		hold_off(3);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= cnt;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.feat_count = cnt;
	endtask

	function automatic logic signed [mmfs_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3, 4, 5: return $urandom;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic run_phase(input logic [mmfs_pkg::COUNT_W-1:0] cnt, input int idle_pct,
			input int n_items);
		int                            taken;
		int                            lim;
		int                            n_train;
		int                            n_scale;
		bit                            paused;
		logic                          m;
		logic [mmfs_pkg::INDEX_W-1:0]  idx;
		taken = 0;
		paused = 1'b0;
		write_count(cnt);
		lim = (int'(cnt) < NFEAT) ? int'(cnt) : NFEAT;
		while (taken < n_items) begin
			if (!paused && taken >= n_items / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			if (lim == 0 || $urandom_range(0, 3) == 0)
				idx = mmfs_pkg::INDEX_W'($urandom_range(0, NFEAT - 1));
			else
				idx = mmfs_pkg::INDEX_W'($urandom_range(0, lim - 1));
			if ($urandom_range(0, 9) < 7) begin
				// train a few values into one feature, then scale against it
				n_train = $urandom_range(1, 4);
				n_scale = $urandom_range(1, 3);
				repeat (n_train) begin
					send_item(mmfs_pkg::MODE_TRAIN, idx, pick_value(), idle_pct);
					taken++;
				end
				repeat (n_scale) begin
					send_item(mmfs_pkg::MODE_SCALE, idx, pick_value(), idle_pct);
					taken++;
				end
			end else begin
				m = 1'($urandom_range(0, 1));
				idx = mmfs_pkg::INDEX_W'($urandom_range(0, NFEAT - 1));
				send_item(m, idx, $urandom, idle_pct);
				taken++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// untrained, constant, full-range spans, values outside the trained range
		send_item(mmfs_pkg::MODE_SCALE, 6'd0, 32'sd0, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd63, 32'sh8000_0000, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd5, 32'sd100, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sd100, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sh8000_0000, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sh7fff_ffff, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd5, 32'sh8000_0000, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd5, 32'sh7fff_ffff, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sh8000_0000, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sh7fff_ffff, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sd0, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, -32'sd1, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd63, -32'sd7, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd63, 32'sd9, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd63, 32'sd1, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd63, 32'sh7fff_ffff, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd63, 32'sh8000_0000, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd0, 32'sh7fff_ffff, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd0, 32'sh8000_0000, 0);

		// shrinking the count hides features but keeps what they learned
		write_count(7'd1);
		send_item(mmfs_pkg::MODE_SCALE, 6'd5, 32'sd3, 0);
		send_item(mmfs_pkg::MODE_TRAIN, 6'd2, 32'sd50, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd0, 32'sd4, 0);
		write_count(7'd0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd0, 32'sd4, 0);
		write_count(7'd127);
		send_item(mmfs_pkg::MODE_SCALE, 6'd63, 32'sd2, 0);
		send_item(mmfs_pkg::MODE_SCALE, 6'd2, 32'sd2, 0);

		run_phase(7'd64, 0, 220);
		run_phase(7'd1, 67, 80);
		run_phase(7'd127, 20, 200);
		run_phase(7'd0, 0, 30);
		run_phase(7'($urandom_range(2, 63)), 67, 200);
		run_phase(7'd64, 20, 200);

		wait_drained();
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_norms.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
